FILE: rtl/core/bqlp_pkg.sv
// ----------------------------------------------------------------------------
// bqlp_pkg
// shared types, widths, register codes and reset values of the biquad block
// ----------------------------------------------------------------------------
package bqlp_pkg;

  localparam int CH_W     = 3;
  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 32;
  localparam int HIST_W   = 32;
  localparam int WARMUP_W = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // register index codes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0     = 3'd0,
    REG_B1     = 3'd1,
    REG_B2     = 3'd2,
    REG_A1     = 3'd3,
    REG_A2     = 3'd4,
    REG_WARMUP = 3'd5
  } reg_idx_e;

  // reset values
  localparam logic signed [COEF_W-1:0] B0_RESET = 32'sd35193898;
  localparam logic signed [COEF_W-1:0] B1_RESET = 32'sd70387796;
  localparam logic signed [COEF_W-1:0] B2_RESET = 32'sd35193898;
  localparam logic signed [COEF_W-1:0] A1_RESET = -32'sd200735458;
  localparam logic signed [COEF_W-1:0] A2_RESET = 32'sd73070816;
  localparam logic [WARMUP_W-1:0]      WARMUP_RESET = 10'd100;

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
  } coef_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x1;
    logic signed [SAMPLE_W-1:0] x2;
    logic signed [HIST_W-1:0]   y1;
    logic signed [HIST_W-1:0]   y2;
  } hist_t;

endpackage

FILE: rtl/core/bqlp_in_if.sv
// ----------------------------------------------------------------------------
// bqlp_in_if
// sample input channel: channel tag and signed sample
// ----------------------------------------------------------------------------
interface bqlp_in_if import bqlp_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic [CH_W-1:0]            channel;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, channel, sample, input ready);
  modport sink   (input valid, channel, sample, output ready);
endinterface

FILE: rtl/core/bqlp_out_if.sv
// ----------------------------------------------------------------------------
// bqlp_out_if
// result channel: echoed channel, filtered sample, bypass flag
// ----------------------------------------------------------------------------
interface bqlp_out_if import bqlp_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic [CH_W-1:0]            out_channel;
  logic signed [SAMPLE_W-1:0] filtered;
  logic                       bypassed;

  modport source (output valid, out_channel, filtered, bypassed, input ready);
  modport sink   (input valid, out_channel, filtered, bypassed, output ready);
endinterface

FILE: rtl/core/bqlp_cfg_if.sv
// ----------------------------------------------------------------------------
// bqlp_cfg_if
// configuration write channel: register index and write data
// ----------------------------------------------------------------------------
interface bqlp_cfg_if import bqlp_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

FILE: rtl/core/bqlp_cfg_regs.sv
// ----------------------------------------------------------------------------
// bqlp_cfg_regs
// coefficient and warm-up count registers behind the write channel
// ----------------------------------------------------------------------------
module bqlp_cfg_regs import bqlp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  bqlp_cfg_if.sink            cfg_i,
  output coef_t               coef_o,
  output logic [WARMUP_W-1:0] warmup_count_o
);

  coef_t               coef_q;
  logic [WARMUP_W-1:0] warmup_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.b0 <= B0_RESET;
      coef_q.b1 <= B1_RESET;
      coef_q.b2 <= B2_RESET;
      coef_q.a1 <= A1_RESET;
      coef_q.a2 <= A2_RESET;
      warmup_q  <= WARMUP_RESET;
    end else if (cfg_i.valid) begin
      case (reg_idx_e'(cfg_i.index))
        REG_B0:     coef_q.b0 <= cfg_i.wdata;
        REG_B1:     coef_q.b1 <= cfg_i.wdata;
        REG_B2:     coef_q.b2 <= cfg_i.wdata;
        REG_A1:     coef_q.a1 <= cfg_i.wdata;
        REG_A2:     coef_q.a2 <= cfg_i.wdata;
        REG_WARMUP: warmup_q  <= cfg_i.wdata[WARMUP_W-1:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  assign coef_o         = coef_q;
  assign warmup_count_o = warmup_q;

endmodule

FILE: rtl/core/bqlp_history.sv
// ----------------------------------------------------------------------------
// bqlp_history
// per-channel input and output history, read and shifted at one channel
// ----------------------------------------------------------------------------
module bqlp_history import bqlp_pkg::*; #(
  parameter int DEPTH = 8,
  parameter int IDX_W = 3
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [IDX_W-1:0]           idx_i,
  input  logic                       shift_i,
  input  logic signed [SAMPLE_W-1:0] x_new_i,
  input  logic signed [HIST_W-1:0]   y_new_i,
  output hist_t                      hist_o
);

  logic signed [SAMPLE_W-1:0] x1_q [DEPTH];
  logic signed [SAMPLE_W-1:0] x2_q [DEPTH];
  logic signed [HIST_W-1:0]   y1_q [DEPTH];
  logic signed [HIST_W-1:0]   y2_q [DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        x1_q[i] <= '0;
        x2_q[i] <= '0;
        y1_q[i] <= '0;
        y2_q[i] <= '0;
      end
    end else if (shift_i) begin
      x2_q[idx_i] <= x1_q[idx_i];
      x1_q[idx_i] <= x_new_i;
      y2_q[idx_i] <= y1_q[idx_i];
      y1_q[idx_i] <= y_new_i;
    end
  end

  assign hist_o.x1 = x1_q[idx_i];
  assign hist_o.x2 = x2_q[idx_i];
  assign hist_o.y1 = y1_q[idx_i];
  assign hist_o.y2 = y2_q[idx_i];

endmodule

FILE: rtl/core/bqlp_datapath.sv
// ----------------------------------------------------------------------------
// bqlp_datapath
// five products, exact sum, rounding and saturation of one filter step
// ----------------------------------------------------------------------------
module bqlp_datapath import bqlp_pkg::*; #(
  parameter int COEF_FRAC_BITS = 28
) (
  input  coef_t                      coef_i,
  input  hist_t                      hist_i,
  input  logic signed [SAMPLE_W-1:0] x_i,
  input  logic                       bypass_i,
  output logic signed [HIST_W-1:0]   y_q16_o,
  output logic signed [SAMPLE_W-1:0] result_o
);

  localparam int FF_W  = COEF_W + SAMPLE_W;
  localparam int FB_W  = COEF_W + HIST_W;
  localparam int ACC_W = FB_W + 2;
  localparam int RND_W = HIST_W + 2;
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(64'sd2147483648);
  localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [RND_W-1:0] OUT_HALF = RND_W'(32768);
  localparam logic signed [RND_W-1:0] R_HI = RND_W'(32767);
  localparam logic signed [RND_W-1:0] R_LO = -RND_W'(32768);

  logic signed [FF_W-1:0]  m0, m1, m2;
  logic signed [FB_W-1:0]  m3, m4;
  logic signed [ACC_W-1:0] acc, acc_sh;
  logic signed [HIST_W-1:0] y_sat;
  logic signed [RND_W-1:0] r;
  logic signed [SAMPLE_W-1:0] r_sat;

  assign m0 = coef_i.b0 * x_i;
  assign m1 = coef_i.b1 * hist_i.x1;
  assign m2 = coef_i.b2 * hist_i.x2;
  assign m3 = coef_i.a1 * hist_i.y1;
  assign m4 = coef_i.a2 * hist_i.y2;

  // feedforward terms carry the sample scaled to q16.16
  assign acc = (ACC_W'(m0) <<< 16) + (ACC_W'(m1) <<< 16) + (ACC_W'(m2) <<< 16)
             - ACC_W'(m3) - ACC_W'(m4);

  // round half up into q16.16
  assign acc_sh = (acc + ACC_HALF) >>> COEF_FRAC_BITS;

  always_comb begin
    if (acc_sh > SAT_HI) begin
      y_sat = HIST_W'(SAT_HI);
    end else if (acc_sh < SAT_LO) begin
      y_sat = HIST_W'(SAT_LO);
    end else begin
      y_sat = acc_sh[HIST_W-1:0];
    end
  end

  assign r = (RND_W'(y_sat) + OUT_HALF) >>> 16;

  always_comb begin
    if (r > R_HI) begin
      r_sat = SAMPLE_W'(R_HI);
    end else if (r < R_LO) begin
      r_sat = SAMPLE_W'(R_LO);
    end else begin
      r_sat = r[SAMPLE_W-1:0];
    end
  end

  assign y_q16_o  = bypass_i ? {x_i, 16'h0000} : y_sat;
  assign result_o = bypass_i ? x_i : r_sat;

endmodule

FILE: rtl/core/multichannel_biquad_lowpass_warmup.sv
// ----------------------------------------------------------------------------
// multichannel_biquad_lowpass_warmup
// per-channel direct-form-1 biquad low-pass with a shared warm-up bypass
// ----------------------------------------------------------------------------
// path: input word to result word through the input register and the result register
// throughput: 1 word per cycle unless out_o.ready stalls, set by the single filter pass
// reset: coefficients and warm-up count take their defaults, all channel history
//   and the warm-up counter clear to zero, no word is held
// ----------------------------------------------------------------------------
module multichannel_biquad_lowpass_warmup import bqlp_pkg::*; #(
  parameter int CHANNELS       = 8,
  parameter int COEF_FRAC_BITS = 28
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bqlp_in_if.sink    in_i,
  bqlp_out_if.source out_o,
  bqlp_cfg_if.sink   cfg_i
);

  // only channels reachable through the 3-bit tag need storage
  localparam int TAGS  = 1 << CH_W;
  localparam int DEPTH = (CHANNELS < TAGS) ? CHANNELS : TAGS;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  coef_t               coef;
  logic [WARMUP_W-1:0] warmup_count;
  hist_t               hist;

  // input register
  logic                       s1_valid_q, s1_valid_d;
  logic [CH_W-1:0]            s1_channel_q;
  logic signed [SAMPLE_W-1:0] s1_sample_q;

  // result register
  logic                       out_valid_q, out_valid_d;
  logic [CH_W-1:0]            out_channel_q;
  logic signed [SAMPLE_W-1:0] filtered_q;
  logic                       bypassed_q;

  logic [WARMUP_W-1:0] warmup_seen_q, warmup_seen_d;

  logic                       in_take;
  logic                       advance;
  logic                       step;
  logic                       bypass;
  logic [CH_W-1:0]            ch_fold;
  logic [IDX_W-1:0]           ch_idx;
  logic signed [HIST_W-1:0]   y_q16;
  logic signed [SAMPLE_W-1:0] result;

  bqlp_cfg_regs u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_i),
    .coef_o         (coef),
    .warmup_count_o (warmup_count)
  );

  // result register frees when empty or being taken
  assign advance     = !out_valid_q || out_o.ready;
  assign step        = s1_valid_q && advance;
  assign in_i.ready  = !s1_valid_q || advance;
  assign in_take     = in_i.valid && in_i.ready;

  // tags beyond the channel count fold back onto the stored channels,
  // by repeated compare and subtract over the few tag values
  always_comb begin
    ch_fold = s1_channel_q;
    for (int i = 0; i < TAGS; i++) begin
      if (32'(ch_fold) >= CHANNELS) begin
        ch_fold = ch_fold - CH_W'(CHANNELS);
      end
    end
  end

  assign ch_idx = IDX_W'(ch_fold);

  // shared warm-up: pass-through while fewer than warmup_count words have bypassed
  assign bypass = warmup_seen_q < warmup_count;

  bqlp_history #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_hist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .idx_i   (ch_idx),
    .shift_i (step),
    .x_new_i (s1_sample_q),
    .y_new_i (y_q16),
    .hist_o  (hist)
  );

  bqlp_datapath #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dp (
    .coef_i   (coef),
    .hist_i   (hist),
    .x_i      (s1_sample_q),
    .bypass_i (bypass),
    .y_q16_o  (y_q16),
    .result_o (result)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_take) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = s1_valid_q;
    end
  end

  // counter stops at warmup_count, so it never wraps
  assign warmup_seen_d = (step && bypass) ? warmup_seen_q + 1'b1 : warmup_seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      warmup_seen_q <= '0;
    end else begin
      s1_valid_q    <= s1_valid_d;
      out_valid_q   <= out_valid_d;
      warmup_seen_q <= warmup_seen_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_channel_q <= in_i.channel;
      s1_sample_q  <= in_i.sample;
    end
    if (step) begin
      out_channel_q <= s1_channel_q;
      filtered_q    <= result;
      bypassed_q    <= bypass;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.out_channel = out_channel_q;
  assign out_o.filtered    = filtered_q;
  assign out_o.bypassed    = bypassed_q;

endmodule

FILE: verif/multichannel_biquad_lowpass_warmup_test.sv
// ----------------------------------------------------------------------------
// multichannel_biquad_lowpass_warmup_test
// self-checking bench for the multichannel biquad low-pass: drives tagged
// samples and register writes with random gaps and back-pressure, predicts
// each filtered word in exact wide arithmetic and compares it field by field
// ----------------------------------------------------------------------------
module multichannel_biquad_lowpass_warmup_test;
  timeunit 1ns;
  timeprecision 1ps;
  import bqlp_pkg::*;

  localparam int NUM_CH     = 8;
  localparam int FRAC       = 28;
  localparam int LATENCY    = 2;
  localparam int CLK_PERIOD = 10;
  localparam int IDLE_LIMIT = 2000;

  // register indexes the block does not decode
  localparam logic [CFG_IDX_W-1:0] REG_SPARE6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE7 = 3'd7;

  localparam logic [COEF_W-1:0] COEF_MAX  = 32'h7FFF_FFFF;
  localparam logic [COEF_W-1:0] COEF_MIN  = 32'h8000_0000;
  localparam logic [COEF_W-1:0] COEF_ONE  = 32'h1000_0000;
  localparam logic [COEF_W-1:0] COEF_HALF = 32'h0800_0000;

  // one result word as the block should present it
  typedef struct packed {
    logic [CH_W-1:0]            chan;
    logic signed [SAMPLE_W-1:0] value;
    logic                       bypass;
  } filt_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  bqlp_in_if  in_if ();
  bqlp_out_if out_if ();
  bqlp_cfg_if cfg_if ();

  multichannel_biquad_lowpass_warmup #(
    .CHANNELS       (NUM_CH),
    .COEF_FRAC_BITS (FRAC)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // filter state mirrored on the bench side
  coef_t                      coef_m;
  logic [WARMUP_W-1:0]        warm_limit;
  logic [WARMUP_W-1:0]        warm_seen;
  logic signed [SAMPLE_W-1:0] x_hist1 [NUM_CH];
  logic signed [SAMPLE_W-1:0] x_hist2 [NUM_CH];
  logic signed [HIST_W-1:0]   y_hist1 [NUM_CH];
  logic signed [HIST_W-1:0]   y_hist2 [NUM_CH];

  // filtered words still owed by the block, oldest first
  filt_word_t filtered_due[$];

  int errors    = 0;
  int n_sent    = 0;
  int n_checked = 0;
  int n_bypass  = 0;
  int n_writes  = 0;
  int quiet_cycles = 0;
  bit gaps_on   = 1'b1;
  bit stalls_on = 1'b1;

  // 32x32 signed product carried at full width so five terms sum exactly
  function automatic logic signed [71:0] wide_mul(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
    logic signed [71:0] wa;
    logic signed [71:0] wb;
    wa = a;
    wb = b;
    return wa * wb;
  endfunction

  // advance one channel of the filter by one sample, return the word it yields
  function automatic filt_word_t biquad_next(input logic [CH_W-1:0] chan,
                                             input logic signed [SAMPLE_W-1:0] x);
    logic signed [71:0]       acc;
    logic signed [HIST_W-1:0] x_q16;
    logic signed [HIST_W-1:0] x1_q16;
    logic signed [HIST_W-1:0] x2_q16;
    logic signed [HIST_W-1:0] y_q16;
    logic signed [HIST_W:0]   rounded;
    int                       slot;
    filt_word_t               res;
    slot     = int'(chan) % NUM_CH;
    x_q16    = {x, 16'h0000};
    x1_q16   = {x_hist1[slot], 16'h0000};
    x2_q16   = {x_hist2[slot], 16'h0000};
    res.chan = chan;
    if (warm_seen < warm_limit) begin
      // warm-up: sample passes straight through and seeds the output history
      y_q16      = x_q16;
      res.value  = x;
      res.bypass = 1'b1;
      warm_seen  = warm_seen + 1'b1;
    end else begin
      acc = wide_mul(coef_m.b0, x_q16) + wide_mul(coef_m.b1, x1_q16)
          + wide_mul(coef_m.b2, x2_q16) - wide_mul(coef_m.a1, y_hist1[slot])
          - wide_mul(coef_m.a2, y_hist2[slot]);
      // Q(frac+16) to Q16.16, round half up
      acc = (acc + (72'sd1 <<< (FRAC - 1))) >>> FRAC;
      if (acc > 72'sd2147483647) begin
        y_q16 = 32'h7FFF_FFFF;
      end else if (acc < -72'sd2147483648) begin
        y_q16 = 32'h8000_0000;
      end else begin
        y_q16 = acc[31:0];
      end
      rounded = (33'(y_q16) + 33'sd32768) >>> 16;
      // only the top end can step past the 16-bit range here
      if (rounded > 33'sd32767) begin
        res.value = 16'h7FFF;
      end else begin
        res.value = rounded[15:0];
      end
      res.bypass = 1'b0;
    end
    x_hist2[slot] = x_hist1[slot];
    x_hist1[slot] = x;
    y_hist2[slot] = y_hist1[slot];
    y_hist1[slot] = y_q16;
    return res;
  endfunction

  // extremes now and then, otherwise any 16-bit pattern
  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(15))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'sh0000;
      3:       return 16'shFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // kinds: keep default, at most one in magnitude, any pattern, max, min, zero or one
  function automatic logic [COEF_W-1:0] pick_coef(input int kind,
                                                  input logic [COEF_W-1:0] dflt);
    logic [31:0] r;
    r = $urandom;
    case (kind)
      0: return dflt;
      1: return {{3{r[28]}}, r[28:0]};
      2: return r;
      default: begin
        case (r[1:0])
          2'd0:    return COEF_MAX;
          2'd1:    return COEF_MIN;
          2'd2:    return '0;
          default: return COEF_ONE;
        endcase
      end
    endcase
  endfunction

  // send one tagged sample, optionally after a random gap of idle cycles
  task automatic push_sample(input logic [CH_W-1:0] chan,
                             input logic signed [SAMPLE_W-1:0] x);
    filt_word_t w;
    while (gaps_on && $urandom_range(99) < 30) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.channel <= chan;
    in_if.sample  <= x;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    w = biquad_next(chan, x);
    filtered_due.push_back(w);
    n_sent++;
    if (w.bypass) n_bypass++;
  endtask

  // stop sending and wait for every owed word, then let the pipe empty
  task automatic hold_until_drained();
    in_if.valid <= 1'b0;
    while (filtered_due.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  // register write, only ever issued with the block idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    hold_until_drained();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.wdata <= data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    case (idx)
      REG_B0:     coef_m.b0 = data;
      REG_B1:     coef_m.b1 = data;
      REG_B2:     coef_m.b2 = data;
      REG_A1:     coef_m.a1 = data;
      REG_A2:     coef_m.a2 = data;
      REG_WARMUP: warm_limit = data[WARMUP_W-1:0];
      default:    ;
    endcase
    n_writes++;
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_coefs(input logic [COEF_W-1:0] b0, input logic [COEF_W-1:0] b1,
                             input logic [COEF_W-1:0] b2, input logic [COEF_W-1:0] a1,
                             input logic [COEF_W-1:0] a2);
    write_reg(REG_B0, b0);
    write_reg(REG_B1, b1);
    write_reg(REG_B2, b2);
    write_reg(REG_A1, a1);
    write_reg(REG_A2, a2);
  endtask

  // reopen the warm-up for a given number of words; junk in the unused bits
  task automatic write_warmup_window(input int extra);
    int want;
    want = int'(warm_seen) + extra;
    if (want > 1023) want = 1023;
    write_reg(REG_WARMUP, {22'($urandom), 10'(want)});
  endtask

  // reset defaults: the first words bypass, then the default low-pass runs
  task automatic test_reset_warmup();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    repeat (int'(WARMUP_RESET) + 30) push_sample(3'($urandom_range(NUM_CH - 1)), rand_sample());
  endtask

  // hand-picked words: saturation both ways, unity and half gain,
  // warm-up lowered and reopened, writes to undecoded indexes
  task automatic test_directed_extremes();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    // counter is already past zero, so filtering takes over
    write_reg(REG_WARMUP, 32'hFFFF_FC00);
    // every term pushes the same way: hard saturation
    write_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN);
    repeat (3) push_sample(3'd0, 16'sh7FFF);
    repeat (3) push_sample(3'd7, 16'sh8000);
    write_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MAX, COEF_MAX);
    push_sample(3'd0, 16'sh8000);
    push_sample(3'd7, 16'sh7FFF);
    push_sample(3'd3, 16'sh0000);
    push_sample(3'd3, 16'shFFFF);
    write_coefs('0, '0, '0, '0, '0);
    push_sample(3'd2, 16'sh3039);
    // undecoded indexes must leave every coefficient alone
    write_reg(REG_SPARE6, $urandom);
    write_reg(REG_SPARE7, $urandom);
    push_sample(3'd2, 16'sh7FFF);
    write_coefs(COEF_ONE, '0, '0, '0, '0);
    push_sample(3'd1, 16'sh8000);
    push_sample(3'd1, 16'sh7FFF);
    // half gain exposes the round-half-up rule
    write_coefs(COEF_HALF, '0, '0, '0, '0);
    push_sample(3'd1, 16'sh0001);
    push_sample(3'd1, 16'shFFFF);
    push_sample(3'd1, 16'sh8000);
    write_warmup_window(3);
    push_sample(3'd5, 16'sh8000);
    push_sample(3'd5, 16'sh7FFF);
    push_sample(3'd5, 16'sh0000);
    push_sample(3'd5, 16'sh0064);
  endtask

  // phases of random coefficient sets and warm-up windows, random words
  task automatic test_random_phases(input int n_phases, input int per_phase);
    int p;
    for (p = 0; p < n_phases; p++) begin
      write_coefs(pick_coef($urandom_range(3), B0_RESET), pick_coef($urandom_range(3), B1_RESET),
                  pick_coef($urandom_range(3), B2_RESET), pick_coef($urandom_range(3), A1_RESET),
                  pick_coef($urandom_range(3), A2_RESET));
      if ($urandom_range(1)) begin
        write_warmup_window($urandom_range(12));
      end else begin
        // at or below the counter: no bypass this phase
        write_reg(REG_WARMUP, {22'($urandom), 10'($urandom_range(int'(warm_seen)))});
      end
      // one phase runs flat out on both sides
      gaps_on   = (p != 2);
      stalls_on = (p != 2);
      repeat (per_phase) push_sample(3'($urandom_range(NUM_CH - 1)), rand_sample());
    end
  endtask

  // largest warm-up count: everything after it bypasses
  task automatic test_warmup_ceiling();
    write_reg(REG_WARMUP, 32'h0000_03FF);
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    repeat (50) push_sample(3'($urandom_range(NUM_CH - 1)), rand_sample());
  endtask

  // result side back-pressure
  always @(posedge clk_i) begin
    out_if.ready <= !stalls_on || ($urandom_range(99) >= 30);
  end

  // compare each accepted word with the oldest prediction
  always @(posedge clk_i) begin : check_word
    filt_word_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (filtered_due.size() == 0) begin
        $error("result word with nothing outstanding: ch %0d value %0d",
               out_if.out_channel, out_if.filtered);
        errors++;
      end else begin
        want = filtered_due.pop_front();
        n_checked++;
        if (out_if.out_channel !== want.chan) begin
          $error("out_channel: expected %0d, got %0d", want.chan, out_if.out_channel);
          errors++;
        end
        if (out_if.filtered !== want.value) begin
          $error("filtered: expected %0d, got %0d", want.value, out_if.filtered);
          errors++;
        end
        if (out_if.bypassed !== want.bypass) begin
          $error("bypassed: expected %0d, got %0d", want.bypass, out_if.bypassed);
          errors++;
        end
      end
    end
  end

  // watchdog: too long without any handshake ends the run
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
        || (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == IDLE_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d words outstanding",
               IDLE_LIMIT, filtered_due.size());
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int k;
    rst_ni        <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.channel <= '0;
    in_if.sample  <= '0;
    cfg_if.valid  <= 1'b0;
    cfg_if.index  <= '0;
    cfg_if.wdata  <= '0;
    coef_m     = '{b0: B0_RESET, b1: B1_RESET, b2: B2_RESET, a1: A1_RESET, a2: A2_RESET};
    warm_limit = WARMUP_RESET;
    warm_seen  = '0;
    for (k = 0; k < NUM_CH; k++) begin
      x_hist1[k] = '0;
      x_hist2[k] = '0;
      y_hist1[k] = '0;
      y_hist2[k] = '0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_warmup();
    test_directed_extremes();
    test_random_phases(10, 125);
    test_warmup_ceiling();

    // drain, then give the pipe time to show any stray word
    hold_until_drained();
    repeat (LATENCY + 4) @(posedge clk_i);

    $display("covered %0d samples over %0d channels (%0d in warm-up bypass), %0d register writes",
             n_sent, NUM_CH, n_bypass, n_writes);
    $display("checked %0d result words, %0d mismatches", n_checked, errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/bqlp_pkg.sv
rtl/core/bqlp_in_if.sv
rtl/core/bqlp_out_if.sv
rtl/core/bqlp_cfg_if.sv
rtl/core/bqlp_cfg_regs.sv
rtl/core/bqlp_history.sv
rtl/core/bqlp_datapath.sv
rtl/core/multichannel_biquad_lowpass_warmup.sv
verif/multichannel_biquad_lowpass_warmup_test.sv
